>>> rtl/crc8fr_pkg.sv
// Shared types, constants and the CRC-8 bit step for the frame receiver.
// No dependencies; every other file in rtl/ imports this package.
package crc8fr_pkg;

  localparam int MAX_FRAME_LEN = 64;
  localparam int BODY_DEPTH    = 64;
  localparam int BODY_AW       = $clog2(BODY_DEPTH);

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_INIT  = 8'h00;
  localparam logic [7:0] SYNC_1ST  = 8'hAA;
  localparam logic [7:0] SYNC_2ND  = 8'h55;
  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] LEN_MAX   = 8'(MAX_FRAME_LEN);
  localparam logic [2:0] BIT_LAST  = 3'd6;

  typedef enum logic [2:0] {
    S_SYNC1,
    S_SYNC2,
    S_LEN,
    S_BODY,
    S_CRC,
    S_EMIT
  } rx_state_t;

  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_cmd_t;

  // One MSB-first step of the 0x07 CRC with one message bit.
  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
    logic fb;
    fb = crc[7] ^ b;
    return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
  endfunction

endpackage

>>> rtl/crc8_frame_receiver_unit.sv
// Sync/length/CRC-8 frame receiver. Takes one received byte per input item and
// hunts for the pair 0xAA 0x55, then a length byte L in 2..64, then L-1 body
// bytes and a CRC-8 byte (poly 0x07, init 0, over L and the body). A frame whose
// CRC matches is delivered as L-1 result items, last_of_frame set on the final
// one; a bad length or CRC drops the frame silently. Sync, CRC and rejected
// length bytes do not stall the input; a legal length byte and each body byte
// start the bit-serial CRC register, which folds in one bit per cycle, and the
// input is stalled until all eight bits are in. After a good CRC byte the input
// is stalled while the body is read back from the 64-entry store, each result
// by a memory read and then a load of the output register, which waits while
// the output stalls. No clearing pass is needed after reset.
// Depends on crc8fr_pkg, crc8fr_rx_ctrl and crc8fr_len_check.
module crc8_frame_receiver_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_body_byte,
  output logic [5:0] out_body_length,
  output logic       out_last_of_frame
);
  import crc8fr_pkg::*;

  rx_state_t  state;
  logic       crc_busy;
  logic [5:0] emit_idx;
  logic [5:0] body_len;
  logic       idx_in_range;

  crc8fr_rx_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_body_byte     (out_body_byte),
    .out_body_length   (out_body_length),
    .out_last_of_frame (out_last_of_frame),
    .state             (state),
    .crc_busy          (crc_busy),
    .emit_idx          (emit_idx),
    .body_len          (body_len)
  );

  crc8fr_len_check u_len_check (
    .emit_idx     (emit_idx),
    .body_len     (body_len),
    .idx_in_range (idx_in_range)
  );

  // CRC must have settled before the body is read back
  a_emit_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_EMIT) |-> !crc_busy)
    else $error("CRC still busy during emission");

  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_EMIT) |-> idx_in_range)
    else $error("emit index beyond frame body");

  a_body_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (state == S_BODY || state == S_LEN) &&
     !(state == S_LEN && (in_rx_byte < LEN_MIN || in_rx_byte > LEN_MAX)))
    |=> crc_busy)
    else $error("accepted byte did not start the CRC");

  a_out_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_body_length != 6'd0))
    else $error("result item with zero body length");

endmodule

>>> rtl/crc8fr_crc_serial.sv
// Bit-serial CRC-8 register: one message bit per cycle, busy until all eight bits of a byte are folded in.
// Depends on crc8fr_pkg (crc_cmd_t, crc_bit).
module crc8fr_crc_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  crc8fr_pkg::crc_cmd_t cmd,
  output logic                busy,
  output logic [7:0]          crc
);
  import crc8fr_pkg::*;

  logic [7:0] crc_r, crc_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] base;

  // first bit is folded in on the start cycle, the other seven follow
  always_comb begin
    base     = cmd.clear ? CRC_INIT : crc_r;
    crc_nxt  = crc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      crc_nxt  = crc_bit(base, cmd.data[7]);
      sh_nxt   = {cmd.data[6:0], 1'b0};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_bit(crc_r, sh_r[7]);
      sh_nxt  = {sh_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == BIT_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign busy = busy_r;
  assign crc  = crc_r;

endmodule

>>> rtl/crc8fr_body_ram.sv
// Frame body store: one write port, one read port with registered data.
// Depends on crc8fr_pkg (BODY_DEPTH, BODY_AW).
module crc8fr_body_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [crc8fr_pkg::BODY_AW-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [crc8fr_pkg::BODY_AW-1:0] raddr,
  output logic [7:0]                    rdata
);
  import crc8fr_pkg::*;

  logic [7:0] mem [BODY_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/crc8fr_rx_ctrl.sv
// Frame parser and body emitter: sync/length/body/CRC sequencing, output register.
// Depends on crc8fr_pkg; instantiates crc8fr_crc_serial and crc8fr_body_ram.
module crc8fr_rx_ctrl (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_body_byte,
  output logic [5:0] out_body_length,
  output logic       out_last_of_frame,
  output crc8fr_pkg::rx_state_t state,
  output logic       crc_busy,
  output logic [5:0] emit_idx,
  output logic [5:0] body_len
);
  import crc8fr_pkg::*;

  rx_state_t state_r, state_nxt;
  logic [6:0] frame_len_r, frame_len_nxt;
  logic [5:0] body_cnt_r, body_cnt_nxt;
  logic [5:0] emit_idx_r, emit_idx_nxt;
  logic       rd_ok_r, rd_ok_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [5:0] out_len_r;
  logic       out_last_r;

  crc_cmd_t   crc_cmd;
  logic [7:0] crc_val;
  logic       ram_we;
  logic [7:0] ram_rdata;

  logic       in_acc;
  logic       out_load;
  logic       emit_last;
  logic       len_ok;
  logic       body_done;
  logic [5:0] cnt_inc;

  assign in_stall  = crc_busy || (state_r == S_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign body_len  = 6'(frame_len_r - 7'd1);
  assign emit_last = (emit_idx_r == 6'(body_len - 6'd1));
  assign out_load  = (state_r == S_EMIT) && rd_ok_r && (!out_valid_r || !out_stall);
  assign len_ok    = (in_rx_byte >= LEN_MIN) && (in_rx_byte <= LEN_MAX);
  assign cnt_inc   = body_cnt_r + 6'd1;
  assign body_done = ({1'b0, cnt_inc} + 7'd1) >= frame_len_r;

  crc8fr_crc_serial u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  crc8fr_body_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (body_cnt_r),
    .wdata (in_rx_byte),
    .raddr (emit_idx_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_SYNC1: begin
        if (in_acc && in_rx_byte == SYNC_1ST) state_nxt = S_SYNC2;
      end
      S_SYNC2: begin
        if (in_acc) state_nxt = (in_rx_byte == SYNC_2ND) ? S_LEN : S_SYNC1;
      end
      S_LEN: begin
        if (in_acc) state_nxt = len_ok ? S_BODY : S_SYNC1;
      end
      S_BODY: begin
        if (in_acc && body_done) state_nxt = S_CRC;
      end
      S_CRC: begin
        if (in_acc) state_nxt = (crc_val == in_rx_byte) ? S_EMIT : S_SYNC1;
      end
      S_EMIT: begin
        if (out_load && emit_last) state_nxt = S_SYNC1;
      end
      default: begin
        state_nxt = S_SYNC1;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    crc_cmd.start = 1'b0;
    crc_cmd.clear = 1'b0;
    crc_cmd.data  = in_rx_byte;
    ram_we        = 1'b0;
    frame_len_nxt = frame_len_r;
    body_cnt_nxt  = body_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    rd_ok_nxt     = 1'b0;
    case (state_r)
      S_LEN: begin
        if (in_acc && len_ok) begin
          frame_len_nxt = in_rx_byte[6:0];
          body_cnt_nxt  = '0;
          crc_cmd.start = 1'b1;
          crc_cmd.clear = 1'b1;
        end
      end
      S_BODY: begin
        if (in_acc) begin
          ram_we        = 1'b1;
          body_cnt_nxt  = cnt_inc;
          crc_cmd.start = 1'b1;
        end
      end
      S_CRC: begin
        if (in_acc) emit_idx_nxt = '0;
      end
      S_EMIT: begin
        // read address holds while its registered data is fetched and until it is loaded
        if (out_load) begin
          emit_idx_nxt = emit_idx_r + 6'd1;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SYNC1;
      frame_len_r <= '0;
      body_cnt_r  <= '0;
      emit_idx_r  <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_len_r <= frame_len_nxt;
      body_cnt_r  <= body_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      rd_ok_r     <= rd_ok_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= ram_rdata;
      out_len_r  <= body_len;
      out_last_r <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_body_byte     = out_byte_r;
  assign out_body_length   = out_len_r;
  assign out_last_of_frame = out_last_r;
  assign state             = state_r;
  assign emit_idx          = emit_idx_r;

endmodule

>>> rtl/crc8frame_receiver_unit_placeholder.sv
// Top-level wrapper lives in crc8_frame_receiver_unit.sv; this file holds the
// emit index range check used by it. Depends on crc8fr_pkg.
module crc8fr_len_check (
  input  logic [5:0] emit_idx,
  input  logic [5:0] body_len,
  output logic       idx_in_range
);
  import crc8fr_pkg::*;

  assign idx_in_range = (emit_idx < body_len) && (body_len != 6'd0);

endmodule
